// ===== rtl/core/atip_pkg.sv =====
package atip_pkg;

  // Widths fixed by the item fields
  localparam int BASE_W = 6;
  localparam int OFS_W  = 16;

  // Default string length cap
  localparam int unsigned DEFAULT_MAX_LEN = 32'd65535;

  // Character codes
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_X_LO      = 8'h78;
  localparam logic [7:0] CH_X_UP      = 8'h58;
  localparam logic [7:0] CH_A_UP      = 8'h41;
  localparam logic [7:0] CH_Z_UP      = 8'h5A;
  localparam logic [7:0] CH_A_LO      = 8'h61;
  localparam logic [7:0] CH_Z_LO      = 8'h7A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] UP_OFS       = 8'h37;  // 'A' - 10
  localparam logic [7:0] LO_OFS       = 8'h57;  // 'a' - 10
  localparam logic [7:0] DIGIT_NONE   = 8'hFF;

  // Fixed bases
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // Saturation limits
  localparam logic [63:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Byte classification
  typedef struct packed {
    logic       is_ws;
    logic       is_sign;
    logic       is_minus;
    logic       is_dec;
    logic       is_zero;
    logic       is_x;
    logic       is_term;
    logic [7:0] dval;
  } chr_class_t;

  // Accumulator step outcome
  typedef struct packed {
    logic        not_digit;
    logic        overflow;
    logic [63:0] mag_next;
  } acc_t;

  // One result item
  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
    logic               end_valid;
    logic [OFS_W-1:0]   end_offset;
  } res_t;

endpackage

// ===== rtl/core/atip_if.sv =====
// Input channel: one string byte per item
interface atip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// Result channel: one parsed number per item
interface atip_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;
  logic               end_valid;
  logic [15:0]        end_offset;

  modport source (output valid, output value, output status, output end_valid,
                  output end_offset, input ready);
  modport sink (input valid, input value, input status, input end_valid,
                input end_offset, output ready);
endinterface

// Configuration write channel: base register
interface atip_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] base;

  modport source (output valid, output base, input ready);
  modport sink (input valid, input base, output ready);
endinterface

// ===== rtl/core/ascii_to_int64_parser.sv =====
// Channel  | Role | Payload                                       | Handshake
// ---------+------+-----------------------------------------------+------------
// chars    | sink | char_byte[7:0]                                | valid/ready
// results  | src  | value[63:0] s, status[1:0], end_valid, end_offset[15:0] | valid/ready
// cfg      | sink | base[5:0]                                     | valid/ready
//
// One byte is taken per cycle while no terminator is stalled; a taken byte is held in the input
// register and then folded into the parse state through the base multiply-add.
// A terminator clears the parse state at the same edge that loads the result register, which
// then offers the result on the result channel.
// Synchronous reset clears the parse state, the base register and both valid flags.
// A result not yet taken stalls a following terminator and bytes behind it; earlier bytes flow.
module ascii_to_int64_parser #(
  parameter int unsigned MAX_LEN = atip_pkg::DEFAULT_MAX_LEN
) (
  input logic       clk,
  input logic       rst,
  atip_char_if.sink chars,
  atip_res_if.source results,
  atip_cfg_if.sink  cfg
);

  logic                        in_valid;
  logic [7:0]                  in_byte;
  logic                        in_term;
  logic                        in_advance;
  logic                        step;
  logic [atip_pkg::BASE_W-1:0] base;
  logic                        res_valid;
  atip_pkg::res_t              res_data;
  logic                        res_fire;
  atip_pkg::res_t              res_comb;

  // Handshakes
  assign in_term      = (in_byte == atip_pkg::CH_NUL);
  assign in_advance   = !in_term || !res_valid || results.ready;
  assign step         = in_valid && in_advance;
  assign chars.ready  = !in_valid || in_advance;
  assign cfg.ready    = 1'b1;

  atip_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .c        (in_byte),
    .base     (base),
    .res_fire (res_fire),
    .res      (res_comb)
  );

  // Hold the input item until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_byte <= chars.char_byte;
    end
  end

  // Base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= atip_pkg::BASE_AUTO;
    end else if (cfg.valid && cfg.ready) begin
      base <= cfg.base;
    end
  end

  // Result register: load on terminator, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_fire) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_data <= res_comb;
    end
  end

  assign results.valid      = res_valid;
  assign results.value      = res_data.value;
  assign results.status     = res_data.status;
  assign results.end_valid  = res_data.end_valid;
  assign results.end_offset = res_data.end_offset;

  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> !res_valid || results.ready)
    else $error("pending result overwritten");

  ap_step_needs_item: assert property (@(posedge clk) disable iff (rst)
    step |-> in_valid)
    else $error("parser stepped without an input item");

  ap_res_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(res_data))
    else $error("stalled result item changed");

endmodule

// ===== rtl/core/atip_char_decode.sv =====
module atip_char_decode (
  input  logic [7:0]         c,
  output atip_pkg::chr_class_t cls
);

  logic       is_up;
  logic       is_lo;
  logic       is_dec;
  logic [7:0] dval;

  // Classify the byte
  assign is_up        = c inside {[atip_pkg::CH_A_UP:atip_pkg::CH_Z_UP]};
  assign is_lo        = c inside {[atip_pkg::CH_A_LO:atip_pkg::CH_Z_LO]};
  assign is_dec       = c inside {[atip_pkg::CH_ZERO:atip_pkg::CH_NINE]};
  assign cls.is_dec   = is_dec;
  assign cls.is_ws    = (c == atip_pkg::CH_SPACE) ||
                        (c inside {[atip_pkg::CH_TAB:atip_pkg::CH_CR]});
  assign cls.is_minus = (c == atip_pkg::CH_MINUS);
  assign cls.is_sign  = (c == atip_pkg::CH_MINUS) || (c == atip_pkg::CH_PLUS);
  assign cls.is_zero  = (c == atip_pkg::CH_ZERO);
  assign cls.is_x     = (c == atip_pkg::CH_X_LO) || (c == atip_pkg::CH_X_UP);
  assign cls.is_term  = (c == atip_pkg::CH_NUL);
  assign cls.dval     = dval;

  // Digit value, or none for anything else
  always_comb begin
    if (is_dec) begin
      dval = c - atip_pkg::CH_ZERO;
    end else if (is_up) begin
      dval = c - atip_pkg::UP_OFS;
    end else if (is_lo) begin
      dval = c - atip_pkg::LO_OFS;
    end else begin
      dval = atip_pkg::DIGIT_NONE;
    end
  end

endmodule

// ===== rtl/core/atip_accum.sv =====
module atip_accum (
  input  logic [63:0]                   mag,
  input  logic                          negative,
  input  logic [atip_pkg::BASE_W-1:0]   eb,
  input  logic [7:0]                    dval,
  output atip_pkg::acc_t                acc
);

  localparam int PW = 64 + atip_pkg::BASE_W;

  logic [63:0]   limit;
  logic [PW-1:0] prod;
  logic [PW-1:0] sum;

  // Multiply by the base and add the digit at full width
  assign prod = PW'(mag) * PW'(eb);
  assign sum  = prod + PW'(dval);

  // With the digit below the base, exceeding the limit is the overflow test
  assign limit         = negative ? atip_pkg::LIMIT_NEG : atip_pkg::LIMIT_POS;
  assign acc.not_digit = (dval >= 8'(eb));
  assign acc.overflow  = (sum > PW'(limit));
  assign acc.mag_next  = sum[63:0];

endmodule

// ===== rtl/core/atip_parse.sv =====
module atip_parse #(
  parameter int unsigned MAX_LEN = atip_pkg::DEFAULT_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  c,
  input  logic [atip_pkg::BASE_W-1:0] base,
  output logic                        res_fire,
  output atip_pkg::res_t              res
);

  localparam logic [atip_pkg::OFS_W-1:0] OffsetCap =
    (MAX_LEN < 32'd65535) ? atip_pkg::OFS_W'(MAX_LEN) : {atip_pkg::OFS_W{1'b1}};

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_AFTER_SIGN,
    PH_ZERO_SEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                      phase, phase_next;
  logic                        negative, negative_next;
  logic [63:0]                 magnitude, magnitude_next;
  logic [atip_pkg::BASE_W-1:0] eff_base, eff_base_next;
  logic [atip_pkg::OFS_W-1:0]  position, position_next;
  logic [atip_pkg::OFS_W-1:0]  num_start, num_start_next;
  logic [atip_pkg::OFS_W-1:0]  stop_offset, stop_offset_next;
  logic [1:0]                  error_code, error_code_next;

  logic [atip_pkg::BASE_W-1:0] step_eb;
  logic [atip_pkg::OFS_W-1:0]  pos_inc;
  atip_pkg::chr_class_t        cls;
  atip_pkg::acc_t              acc;

  atip_char_decode u_decode (
    .c   (c),
    .cls (cls)
  );

  atip_accum u_accum (
    .mag      (magnitude),
    .negative (negative),
    .eb       (step_eb),
    .dval     (cls.dval),
    .acc      (acc)
  );

  // Advance the offset, saturating at the cap
  assign pos_inc = (position < OffsetCap) ? position + 1'b1 : position;

  // Base used by a digit step in this cycle
  always_comb begin
    case (phase)
      PH_SKIP, PH_AFTER_SIGN: step_eb = (base != atip_pkg::BASE_AUTO) ? base : atip_pkg::BASE_DEC;
      PH_ZERO_SEEN:           step_eb = (eff_base != atip_pkg::BASE_AUTO) ? eff_base
                                                                          : atip_pkg::BASE_OCT;
      default:                step_eb = eff_base;
    endcase
  end

  // Next state for the byte in hand
  always_comb begin
    logic                       do_step;
    logic                       first;
    logic [1:0]                 fin_err;
    logic [atip_pkg::OFS_W-1:0] fin_ds;
    logic [atip_pkg::OFS_W-1:0] fin_stop;

    do_step           = 1'b0;
    first             = 1'b0;
    phase_next        = phase;
    negative_next     = negative;
    magnitude_next    = magnitude;
    eff_base_next     = eff_base;
    position_next     = position;
    num_start_next    = num_start;
    stop_offset_next  = stop_offset;
    error_code_next   = error_code;
    fin_err           = error_code;
    fin_ds            = num_start;
    fin_stop          = stop_offset;
    res               = '0;
    res_fire          = step && cls.is_term;

    if (!cls.is_term) begin
      case (phase)
        PH_SKIP: begin
          if (cls.is_ws) begin
            position_next = pos_inc;
          end else if (cls.is_sign) begin
            negative_next = cls.is_minus;
            position_next = pos_inc;
            phase_next    = PH_AFTER_SIGN;
          end else if (cls.is_dec) begin
            first = 1'b1;
          end else begin
            error_code_next = atip_pkg::ST_INVALID;
            phase_next      = PH_DONE;
          end
        end
        PH_AFTER_SIGN: begin
          first = 1'b1;
        end
        PH_ZERO_SEEN: begin
          if (cls.is_x) begin
            eff_base_next     = atip_pkg::BASE_HEX;
            position_next     = pos_inc;
            num_start_next    = pos_inc;
            phase_next        = PH_DIGITS;
          end else begin
            eff_base_next = step_eb;
            phase_next    = PH_DIGITS;
            do_step       = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_step = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // First byte after whitespace and sign: latch the base
      if (first) begin
        num_start_next = position;
        if (cls.is_zero && ((base == atip_pkg::BASE_AUTO) || (base == atip_pkg::BASE_HEX))) begin
          eff_base_next  = base;
          magnitude_next = '0;
          position_next  = pos_inc;
          phase_next     = PH_ZERO_SEEN;
        end else begin
          eff_base_next = step_eb;
          phase_next    = PH_DIGITS;
          do_step       = 1'b1;
        end
      end

      // Accumulate one digit, or stop on a non-digit or overflow
      if (do_step) begin
        if (acc.not_digit) begin
          phase_next       = PH_DONE;
          stop_offset_next = position;
        end else if (acc.overflow) begin
          error_code_next  = atip_pkg::ST_RANGE;
          phase_next       = PH_DONE;
          stop_offset_next = position;
        end else begin
          magnitude_next = acc.mag_next;
          position_next  = pos_inc;
        end
      end
    end else begin
      // Terminator: close the open phase and form the result
      case (phase)
        PH_SKIP: fin_err = atip_pkg::ST_INVALID;
        PH_AFTER_SIGN: begin
          fin_ds   = position;
          fin_stop = position;
        end
        PH_ZERO_SEEN, PH_DIGITS: fin_stop = position;
        default: begin
        end
      endcase

      res.status = fin_err;
      if (fin_err == atip_pkg::ST_INVALID) begin
        res.value     = '0;
        res.end_valid = 1'b0;
      end else begin
        if (fin_err == atip_pkg::ST_RANGE) begin
          res.value = negative ? $signed(atip_pkg::LIMIT_NEG) : $signed(atip_pkg::LIMIT_POS);
        end else begin
          res.value = negative ? $signed(64'd0 - magnitude) : $signed(magnitude);
        end
        res.end_valid = (fin_stop > fin_ds);
      end
      res.end_offset = res.end_valid ? fin_stop : '0;

      phase_next        = PH_SKIP;
      negative_next     = 1'b0;
      magnitude_next    = '0;
      eff_base_next     = '0;
      position_next     = '0;
      num_start_next    = '0;
      stop_offset_next  = '0;
      error_code_next   = atip_pkg::ST_OK;
    end
  end

  // Hold parse state; advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SKIP;
      negative     <= 1'b0;
      magnitude    <= '0;
      eff_base     <= '0;
      position     <= '0;
      num_start    <= '0;
      stop_offset  <= '0;
      error_code   <= atip_pkg::ST_OK;
    end else if (step) begin
      phase        <= phase_next;
      negative     <= negative_next;
      magnitude    <= magnitude_next;
      eff_base     <= eff_base_next;
      position     <= position_next;
      num_start    <= num_start_next;
      stop_offset  <= stop_offset_next;
      error_code   <= error_code_next;
    end
  end

  ap_term_clears: assert property (@(posedge clk) disable iff (rst)
    step && cls.is_term |=> (phase == PH_SKIP) && (position == '0) && (magnitude == '0))
    else $error("parse state not cleared after terminator");

  ap_done_holds: assert property (@(posedge clk) disable iff (rst)
    step && !cls.is_term && (phase == PH_DONE) |=> $stable(magnitude) && $stable(stop_offset))
    else $error("accumulator moved after the number ended");

  ap_pos_cap: assert property (@(posedge clk) disable iff (rst)
    position <= OffsetCap)
    else $error("position above offset cap");

  ap_invalid_res: assert property (@(posedge clk) disable iff (rst)
    res_fire && (res.status == atip_pkg::ST_INVALID) |-> (res.value == '0) && !res.end_valid)
    else $error("invalid start result carries a value");

endmodule
